// ===== hw/rtl/assert_macros.svh =====
// Assertion macros for the ripple block's RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on clk_i, off while rst_ni is low
`define WRHW_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Condition that must never be seen at a clock edge
`define WRHW_ASSERT_NEVER(lbl, cond, msg) \
  `WRHW_ASSERT(lbl, !(cond), msg)

`endif

// ===== hw/rtl/wrhw_pkg.sv =====
// Shared constants, types and codes of the water ripple heightfield block
package wrhw_pkg;

  // grid geometry
  localparam int GRID_BITS = 7;
  localparam int GRID_W    = 1 << GRID_BITS;
  localparam int CELL_W    = 2 * GRID_BITS;
  localparam int CELLS     = 1 << CELL_W;
  localparam logic [CELL_W-1:0] CELL_LAST = CELL_W'(CELLS - 1);
  localparam logic [CELL_W-1:0] ROW_STEP  = CELL_W'(GRID_W);
  localparam logic [CELL_W-1:0] CELL_ONE  = CELL_W'(1);

  // height words and the accumulator of the shared unit
  localparam int H_W   = 16;
  localparam int ACC_W = H_W + 2;

  // texture lookup
  localparam int MAX_TEX_LOG2 = 10;
  localparam int TEX_W        = MAX_TEX_LOG2;
  localparam int CFG_W        = 4;
  localparam logic [CFG_W-1:0] CFG_LOG2_RST = CFG_W'(7);
  localparam logic [CFG_W-1:0] CFG_LOG2_MAX = CFG_W'(MAX_TEX_LOG2);
  localparam int OUT_W        = 20;

  // input field widths
  localparam int COORD_W = 7;
  localparam int STR_W   = 10;
  localparam int IDX_W   = 14;

  // stream widths
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 24;

  typedef enum logic {
    REQ_TICK   = 1'b0,
    REQ_LOOKUP = 1'b1
  } req_e;

  typedef enum logic [0:0] {
    REG_TEX_WIDTH_LOG2  = 1'b0,
    REG_TEX_HEIGHT_LOG2 = 1'b1
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ALU_NOP  = 3'd0,
    ALU_SUM2 = 3'd1,  // acc = a + b
    ALU_ACC2 = 3'd2,  // acc = acc + a + b
    ALU_HSUB = 3'd3,  // acc = (acc >>> 1) - a
    ALU_DAMP = 3'd4   // acc = acc - (acc >>> 6)
  } alu_op_e;

  typedef struct packed {
    req_e               req_type;
    logic               spawn_en;
    logic [COORD_W-1:0] spawn_x;
    logic [COORD_W-1:0] spawn_y;
    logic [STR_W-1:0]   spawn_strength;
    logic [IDX_W-1:0]   cell_index;
  } item_t;

  typedef struct packed {
    alu_op_e        op;
    logic [H_W-1:0] a;
    logic [H_W-1:0] b;
  } alu_cmd_t;

  typedef struct packed {
    logic              en;
    logic [CELL_W-1:0] addr0;
    logic [CELL_W-1:0] addr1;
  } ram_rd_t;

  typedef struct packed {
    logic              en;
    logic [CELL_W-1:0] addr;
    logic [H_W-1:0]    data;
  } ram_wr_t;

  typedef struct packed {
    logic [CFG_W-1:0] wl;
    logic [CFG_W-1:0] hl;
  } tex_cfg_t;

endpackage

// ===== hw/rtl/wrhw_ram.sv =====
// Generic RAM: one write port, two registered read ports
module wrhw_ram #(
  parameter int DEPTH = 16384,
  parameter int WIDTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr0_i,
  input  logic [$clog2(DEPTH)-1:0] raddr1_i,
  output logic [WIDTH-1:0]         rdata0_o,
  output logic [WIDTH-1:0]         rdata1_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata0_q;
  logic [WIDTH-1:0] rdata1_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read data holds while re_i is low
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata0_q <= mem_q[raddr0_i];
      rdata1_q <= mem_q[raddr1_i];
    end
  end

  assign rdata0_o = rdata0_q;
  assign rdata1_o = rdata1_q;

endmodule

// ===== hw/rtl/wrhw_alu.sv =====
// Shared accumulate unit for the per-cell ripple update
module wrhw_alu
  import wrhw_pkg::*;
(
  input  logic                    clk_i,
  input  alu_cmd_t                cmd_i,
  output logic signed [ACC_W-1:0] acc_o
);

  logic signed [ACC_W-1:0] acc_q, acc_d;
  logic signed [ACC_W-1:0] ea, eb;

  assign ea = {{(ACC_W - H_W){cmd_i.a[H_W-1]}}, cmd_i.a};
  assign eb = {{(ACC_W - H_W){cmd_i.b[H_W-1]}}, cmd_i.b};

  always_comb begin
    acc_d = acc_q;
    unique case (cmd_i.op)
      ALU_NOP:  acc_d = acc_q;
      ALU_SUM2: acc_d = ea + eb;
      ALU_ACC2: acc_d = acc_q + ea + eb;
      ALU_HSUB: acc_d = (acc_q >>> 1) - ea;
      ALU_DAMP: acc_d = acc_q - (acc_q >>> 6);
      default:  acc_d = acc_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
  end

  assign acc_o = acc_q;

endmodule

// ===== hw/rtl/wrhw_seq.sv =====
// Sequencer: grid clear, ripple stamp, per-cell update walk and lookup
`include "assert_macros.svh"

module wrhw_seq
  import wrhw_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  // request side
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  item_t                   item_i,
  // lookup result, taken only when the output slot is free
  input  logic                    out_free_i,
  output logic                    res_valid_o,
  output logic [OUT_W-1:0]        res_texel_o,
  input  tex_cfg_t                cfg_i,
  // grid role select: 0 = grid a current
  output logic                    sel_o,
  // logical grid ports, mapped onto the two RAMs by sel_o
  output ram_rd_t                 cur_rd_o,
  output ram_rd_t                 oth_rd_o,
  output ram_wr_t                 cur_wr_o,
  output ram_wr_t                 oth_wr_o,
  input  logic [H_W-1:0]          cur_q0_i,
  input  logic [H_W-1:0]          cur_q1_i,
  input  logic [H_W-1:0]          oth_q0_i,
  // shared unit
  output alu_cmd_t                alu_cmd_o,
  input  logic signed [ACC_W-1:0] acc_i
);

  typedef enum logic [10:0] {
    S_CLEAR = 11'b000_0000_0001,
    S_IDLE  = 11'b000_0000_0010,
    S_STAMP = 11'b000_0000_0100,
    S_CRD0  = 11'b000_0000_1000,
    S_CRD1  = 11'b000_0001_0000,
    S_CACC  = 11'b000_0010_0000,
    S_CHSUB = 11'b000_0100_0000,
    S_CDAMP = 11'b000_1000_0000,
    S_CWB   = 11'b001_0000_0000,
    S_LRD   = 11'b010_0000_0000,
    S_LOUT  = 11'b100_0000_0000
  } state_e;

  typedef enum logic [2:0] {
    PT_CENTER = 3'd0,
    PT_RIGHT  = 3'd1,
    PT_LEFT   = 3'd2,
    PT_DOWN   = 3'd3,
    PT_UP     = 3'd4
  } stamp_pt_e;

  state_e            state_q, state_d;
  stamp_pt_e         pt_q, pt_d;
  logic [CELL_W-1:0] k_q, k_d;
  logic              pend_q, pend_d;
  logic              sel_q, sel_d;
  item_t             item_q, item_d;
  logic              tick_acc;

  // stamp coordinates, wrapped to the grid
  logic [GRID_BITS-1:0] xg, xp, xm, yg, yp, ym;
  logic [STR_W-1:0]     side;

  assign xg   = GRID_BITS'(item_q.spawn_x);
  assign yg   = GRID_BITS'(item_q.spawn_y);
  assign xp   = xg + GRID_BITS'(1);
  assign xm   = xg - GRID_BITS'(1);
  assign yp   = yg + GRID_BITS'(1);
  assign ym   = yg - GRID_BITS'(1);
  assign side = item_q.spawn_strength - (item_q.spawn_strength >> 2);

  // lookup: displacement d = height >>> 4
  localparam int D_W = H_W - 4;
  logic signed [D_W-1:0]   disp;
  logic [CELL_W-1:0]       lk_cell;
  logic [TEX_W-1:0]        d_ext, i_ext, r_ext, wmask, hmask, col, row;

  assign lk_cell = CELL_W'(item_q.cell_index);
  assign disp  = oth_q0_i[H_W-1:4];
  assign d_ext = TEX_W'(disp);
  assign i_ext = TEX_W'(lk_cell);
  assign r_ext = TEX_W'(lk_cell[CELL_W-1:GRID_BITS]);
  assign wmask = ~({TEX_W{1'b1}} << cfg_i.wl);
  assign hmask = ~({TEX_W{1'b1}} << cfg_i.hl);
  assign col   = (i_ext + d_ext) & wmask;
  assign row   = (r_ext - d_ext) & hmask;
  assign res_texel_o = OUT_W'(col) | (OUT_W'(row) << cfg_i.wl);

  assign in_ready_o = (state_q == S_IDLE);
  assign tick_acc   = in_valid_i && in_ready_o && (item_i.req_type == REQ_TICK);
  assign sel_o      = sel_q;

  always_comb begin
    state_d     = state_q;
    pt_d        = pt_q;
    k_d         = k_q;
    pend_d      = pend_q;
    sel_d       = sel_q;
    item_d      = item_q;
    cur_rd_o    = '0;
    oth_rd_o    = '0;
    cur_wr_o    = '0;
    oth_wr_o    = '0;
    alu_cmd_o   = '{op: ALU_NOP, a: '0, b: '0};
    res_valid_o = 1'b0;

    unique case (state_q)
      S_CLEAR: begin
        cur_wr_o = '{en: 1'b1, addr: k_q, data: '0};
        oth_wr_o = '{en: 1'b1, addr: k_q, data: '0};
        if (k_q == CELL_LAST) begin
          k_d     = '0;
          state_d = S_IDLE;
        end else begin
          k_d = k_q + CELL_ONE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          item_d = item_i;
          if (item_i.req_type == REQ_LOOKUP) begin
            state_d = S_LRD;
          end else begin
            sel_d  = ~sel_q;
            k_d    = '0;
            pend_d = 1'b0;
            pt_d   = PT_CENTER;
            state_d = item_i.spawn_en ? S_STAMP : S_CRD0;
          end
        end
      end
      S_STAMP: begin
        cur_wr_o.en   = 1'b1;
        cur_wr_o.data = H_W'(side);
        unique case (pt_q)
          PT_CENTER: begin
            cur_wr_o.addr = {yg, xg};
            cur_wr_o.data = H_W'(item_q.spawn_strength);
            pt_d = PT_RIGHT;
          end
          PT_RIGHT: begin
            cur_wr_o.addr = {yg, xp};
            pt_d = PT_LEFT;
          end
          PT_LEFT: begin
            cur_wr_o.addr = {yg, xm};
            pt_d = PT_DOWN;
          end
          PT_DOWN: begin
            cur_wr_o.addr = {yp, xg};
            pt_d = PT_UP;
          end
          PT_UP: begin
            cur_wr_o.addr = {ym, xg};
            state_d = S_CRD0;
          end
          default: begin
            cur_wr_o.en = 1'b0;
            state_d     = S_CRD0;
          end
        endcase
      end
      // cell k: upper and left neighbours plus old value; finish damping of k-1
      S_CRD0: begin
        cur_rd_o = '{en: 1'b1, addr0: k_q - ROW_STEP, addr1: k_q - CELL_ONE};
        oth_rd_o = '{en: 1'b1, addr0: k_q, addr1: k_q};
        if (pend_q) begin
          alu_cmd_o.op = ALU_DAMP;
        end
        state_d = S_CRD1;
      end
      // right and lower neighbours; write back k-1 before the sum restarts
      S_CRD1: begin
        cur_rd_o = '{en: 1'b1, addr0: k_q + CELL_ONE, addr1: k_q + ROW_STEP};
        if (pend_q) begin
          oth_wr_o = '{en: 1'b1, addr: k_q - CELL_ONE, data: acc_i[H_W-1:0]};
        end
        alu_cmd_o = '{op: ALU_SUM2, a: cur_q0_i, b: cur_q1_i};
        state_d   = S_CACC;
      end
      S_CACC: begin
        alu_cmd_o = '{op: ALU_ACC2, a: cur_q0_i, b: cur_q1_i};
        state_d   = S_CHSUB;
      end
      S_CHSUB: begin
        alu_cmd_o = '{op: ALU_HSUB, a: oth_q0_i, b: '0};
        pend_d    = 1'b1;
        if (k_q == CELL_LAST) begin
          state_d = S_CDAMP;
        end else begin
          k_d     = k_q + CELL_ONE;
          state_d = S_CRD0;
        end
      end
      S_CDAMP: begin
        alu_cmd_o.op = ALU_DAMP;
        state_d      = S_CWB;
      end
      S_CWB: begin
        oth_wr_o = '{en: 1'b1, addr: k_q, data: acc_i[H_W-1:0]};
        pend_d   = 1'b0;
        k_d      = '0;
        state_d  = S_IDLE;
      end
      S_LRD: begin
        oth_rd_o = '{en: 1'b1, addr0: lk_cell, addr1: lk_cell};
        state_d  = S_LOUT;
      end
      S_LOUT: begin
        if (out_free_i) begin
          res_valid_o = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      pt_q    <= PT_CENTER;
      k_q     <= '0;
      pend_q  <= 1'b0;
      sel_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      pt_q    <= pt_d;
      k_q     <= k_d;
      pend_q  <= pend_d;
      sel_q   <= sel_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
  end

  `WRHW_ASSERT_NEVER(a_cur_wr_outside_fill, cur_wr_o.en && !(state_q == S_STAMP || state_q == S_CLEAR), "current grid written outside stamp or clear")
  `WRHW_ASSERT(a_sel_only_on_tick, (sel_q != $past(sel_q)) |-> $past(tick_acc), "grid select moved without a tick")
  `WRHW_ASSERT(a_res_after_read, res_valid_o |-> $past(state_q == S_LRD || state_q == S_LOUT), "lookup result without a grid read")

endmodule

// ===== hw/rtl/water_ripple_heightfield_warp_top.sv =====
// Top level of the two-grid water ripple heightfield with texel warp lookup
//
// Usage:
// - Requests arrive on the s_axis beat channel. tuser selects the kind:
//   0 = tick (swap grids, optional ripple stamp, update of all cells),
//   1 = lookup (one cell turned into a displaced texel index).
// - Lookup results leave on m_axis, one beat per lookup; a tick gives none.
// - cfg_we_i/cfg_index_i/cfg_data_i write the width and height log2 of the
//   texture (0 and 1); write them only while the block is idle.
// - A taken lookup beat reads its cell from the grid RAM, and the result then
//   enters the output register; a new beat is taken only after that.
// - A tick holds the input until its update walk is done (after the stamp,
//   if one is asked for): the walk reads four neighbours and the old value
//   of each cell through the two read ports of the grid RAMs and runs them
//   through one shared accumulate unit, one cell after the other.
// - After reset both grids are cleared one cell a cycle, all 16384 cells,
//   while s_axis_tready_o stays low; config writes are taken meanwhile.
// - A stalled receiver holds the result in the output register; the next
//   beat is still taken, and a following lookup waits at its end until the
//   register frees.
module water_ripple_heightfield_warp_top
  import wrhw_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // request channel
  input  logic                   s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  // [0] spawn_en, [7:1] spawn_x, [14:8] spawn_y, [24:15] spawn_strength,
  // [38:25] cell_index, [39] zero
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata_i,
  // [0] req_type
  input  logic                   s_axis_tuser_i,
  // result channel
  output logic                   m_axis_tvalid_o,
  input  logic                   m_axis_tready_i,
  // [19:0] texel_index, [23:20] zero
  output logic [OUT_TDATA_W-1:0] m_axis_tdata_o,
  // register write port
  input  logic                   cfg_we_i,
  input  logic [0:0]             cfg_index_i,
  input  logic [CFG_W-1:0]       cfg_data_i
);

  // texture size registers, clamped on use
  logic [CFG_W-1:0] wl_q, hl_q;
  tex_cfg_t         cfg;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wl_q <= CFG_LOG2_RST;
      hl_q <= CFG_LOG2_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_TEX_WIDTH_LOG2:  wl_q <= cfg_data_i;
        REG_TEX_HEIGHT_LOG2: hl_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign cfg.wl = (wl_q > CFG_LOG2_MAX) ? CFG_LOG2_MAX : wl_q;
  assign cfg.hl = (hl_q > CFG_LOG2_MAX) ? CFG_LOG2_MAX : hl_q;

  // unpack the request beat
  item_t item;
  assign item.req_type       = req_e'(s_axis_tuser_i);
  assign item.spawn_en       = s_axis_tdata_i[0];
  assign item.spawn_x        = s_axis_tdata_i[7:1];
  assign item.spawn_y        = s_axis_tdata_i[14:8];
  assign item.spawn_strength = s_axis_tdata_i[24:15];
  assign item.cell_index     = s_axis_tdata_i[38:25];

  // sequencer and shared unit
  logic                    sel;
  ram_rd_t                 cur_rd, oth_rd;
  ram_wr_t                 cur_wr, oth_wr;
  logic [H_W-1:0]          cur_q0, cur_q1, oth_q0;
  alu_cmd_t                alu_cmd;
  logic signed [ACC_W-1:0] acc;
  logic                    res_valid;
  logic [OUT_W-1:0]        res_texel;
  logic                    out_free;

  wrhw_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .item_i      (item),
    .out_free_i  (out_free),
    .res_valid_o (res_valid),
    .res_texel_o (res_texel),
    .cfg_i       (cfg),
    .sel_o       (sel),
    .cur_rd_o    (cur_rd),
    .oth_rd_o    (oth_rd),
    .cur_wr_o    (cur_wr),
    .oth_wr_o    (oth_wr),
    .cur_q0_i    (cur_q0),
    .cur_q1_i    (cur_q1),
    .oth_q0_i    (oth_q0),
    .alu_cmd_o   (alu_cmd),
    .acc_i       (acc)
  );

  wrhw_alu u_alu (
    .clk_i (clk_i),
    .cmd_i (alu_cmd),
    .acc_o (acc)
  );

  // grid RAMs: a is current when sel is low, b otherwise
  ram_rd_t        a_rd, b_rd;
  ram_wr_t        a_wr, b_wr;
  logic [H_W-1:0] a_q0, a_q1, b_q0, b_q1;

  assign a_rd = sel ? oth_rd : cur_rd;
  assign b_rd = sel ? cur_rd : oth_rd;
  assign a_wr = sel ? oth_wr : cur_wr;
  assign b_wr = sel ? cur_wr : oth_wr;

  assign cur_q0 = sel ? b_q0 : a_q0;
  assign cur_q1 = sel ? b_q1 : a_q1;
  assign oth_q0 = sel ? a_q0 : b_q0;

  wrhw_ram #(
    .DEPTH (CELLS),
    .WIDTH (H_W)
  ) u_grid_a (
    .clk_i    (clk_i),
    .we_i     (a_wr.en),
    .waddr_i  (a_wr.addr),
    .wdata_i  (a_wr.data),
    .re_i     (a_rd.en),
    .raddr0_i (a_rd.addr0),
    .raddr1_i (a_rd.addr1),
    .rdata0_o (a_q0),
    .rdata1_o (a_q1)
  );

  wrhw_ram #(
    .DEPTH (CELLS),
    .WIDTH (H_W)
  ) u_grid_b (
    .clk_i    (clk_i),
    .we_i     (b_wr.en),
    .waddr_i  (b_wr.addr),
    .wdata_i  (b_wr.data),
    .re_i     (b_rd.en),
    .raddr0_i (b_rd.addr0),
    .raddr1_i (b_rd.addr1),
    .rdata0_o (b_q0),
    .rdata1_o (b_q1)
  );

  // output register
  logic             out_valid_q;
  logic [OUT_W-1:0] out_texel_q;

  assign out_free = !out_valid_q || m_axis_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      out_texel_q <= res_texel;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = OUT_TDATA_W'(out_texel_q);

endmodule
